@@ src/stm_pkg.sv @@
package stm_pkg;

	// Sizes of the text store and the screen
	localparam int MAX_CHARS   = 32;
	localparam int SCREEN_ROWS = 16;
	localparam int GLYPH_COUNT = 46;
	localparam int STORE_DEPTH = 2 * MAX_CHARS;
	localparam int IDX_W       = $clog2(MAX_CHARS);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int ROW_W       = $clog2(SCREEN_ROWS);
	localparam int PIX_W       = 24;
	localparam int GLYPH_W     = 6;
	localparam int LEN_W       = 6;
	localparam int CODE_W      = 8;
	localparam int FONT_W      = 5;
	localparam int CELL_W      = 6;
	localparam int SAY_GLYPHS  = 4;

	// Character mapping
	localparam logic [CODE_W-1:0]  CODE_SPACE   = 8'h20;
	localparam logic [CODE_W-1:0]  CODE_LOWER_A = 8'h61;
	localparam logic [CODE_W-1:0]  CODE_LOWER_Z = 8'h7a;
	localparam logic [CODE_W-1:0]  CASE_OFFSET  = 8'h20;
	localparam logic [CODE_W-1:0]  GLYPH_OFFSET = 8'd45;
	localparam logic [GLYPH_W-1:0] GLYPH_SPACE  = 6'd19;

	// Screen placement
	localparam logic [ROW_W-1:0] ROW_SOLO        = ROW_W'(5);
	localparam logic [ROW_W-1:0] ROW_FIRST_PAIR  = ROW_W'(2);
	localparam logic [ROW_W-1:0] ROW_SECOND_PAIR = ROW_W'(10);
	localparam logic [ROW_W-1:0] SAY_TOP         = ROW_W'(4);
	localparam logic [ROW_W-1:0] SAY_BASE        = ROW_W'(5);
	localparam logic [ROW_W-1:0] SAY_BOTTOM      = ROW_W'(10);

	// Configuration register indexes
	localparam logic CFG_FIRST_LEN  = 1'b0;
	localparam logic CFG_SECOND_LEN = 1'b1;

	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_RESTART = 3'd1,
		OP_TICK    = 3'd2,
		OP_SAY     = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_REFUSED  = 2'd2
	} status_t;

	// Glyph store access
	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [GLYPH_W-1:0] wdata;
		logic               re;
		logic [ADDR_W-1:0]  raddr;
	} ram_req_t;

	// One result item
	typedef struct packed {
		status_t          status;
		logic             has_row;
		logic [ROW_W-1:0] row_index;
		logic [PIX_W-1:0] row_pixels;
		logic             last;
	} result_t;

	// 5x5 font: row r of glyph g, leftmost pixel in bit 4
	function automatic logic [FONT_W-1:0] font_row(input logic [GLYPH_W-1:0] g,
			input logic [2:0] r);
		logic [5*FONT_W-1:0] bits;
		case (g)
			6'd0:  bits = {5'h00, 5'h00, 5'h1f, 5'h00, 5'h00};
			6'd1:  bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
			6'd2:  bits = {5'h02, 5'h02, 5'h04, 5'h08, 5'h08};
			6'd3:  bits = {5'h1f, 5'h13, 5'h15, 5'h19, 5'h1f};
			6'd4:  bits = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h0e};
			6'd5:  bits = {5'h1e, 5'h01, 5'h0e, 5'h10, 5'h1f};
			6'd6:  bits = {5'h1f, 5'h01, 5'h0e, 5'h01, 5'h1f};
			6'd7:  bits = {5'h10, 5'h10, 5'h14, 5'h1f, 5'h04};
			6'd8:  bits = {5'h1f, 5'h10, 5'h1e, 5'h01, 5'h1e};
			6'd9:  bits = {5'h1f, 5'h10, 5'h1f, 5'h11, 5'h1f};
			6'd10: bits = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h04};
			6'd11: bits = {5'h1f, 5'h11, 5'h1f, 5'h11, 5'h1f};
			6'd12: bits = {5'h1f, 5'h11, 5'h1f, 5'h01, 5'h1f};
			6'd13: bits = {5'h00, 5'h04, 5'h00, 5'h04, 5'h00};
			6'd14: bits = {5'h00, 5'h04, 5'h00, 5'h04, 5'h04};
			6'd16: bits = {5'h00, 5'h1f, 5'h00, 5'h1f, 5'h00};
			6'd20: bits = {5'h1f, 5'h11, 5'h11, 5'h1f, 5'h11};
			6'd21: bits = {5'h1f, 5'h11, 5'h1e, 5'h11, 5'h1f};
			6'd22: bits = {5'h1f, 5'h10, 5'h10, 5'h10, 5'h1f};
			6'd23: bits = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h1e};
			6'd24: bits = {5'h1f, 5'h10, 5'h1e, 5'h10, 5'h1f};
			6'd25: bits = {5'h1f, 5'h10, 5'h1e, 5'h10, 5'h10};
			6'd26: bits = {5'h1f, 5'h10, 5'h13, 5'h11, 5'h1f};
			6'd27: bits = {5'h11, 5'h11, 5'h1f, 5'h11, 5'h11};
			6'd28: bits = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h1f};
			6'd29: bits = {5'h03, 5'h01, 5'h01, 5'h11, 5'h1f};
			6'd30: bits = {5'h11, 5'h12, 5'h1c, 5'h12, 5'h11};
			6'd31: bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
			6'd32: bits = {5'h11, 5'h1b, 5'h15, 5'h11, 5'h11};
			6'd33: bits = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
			6'd34: bits = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h0e};
			6'd35: bits = {5'h1e, 5'h11, 5'h1e, 5'h10, 5'h10};
			6'd36: bits = {5'h1f, 5'h11, 5'h11, 5'h1f, 5'h04};
			6'd37: bits = {5'h1e, 5'h11, 5'h1e, 5'h11, 5'h11};
			6'd38: bits = {5'h1f, 5'h10, 5'h1f, 5'h01, 5'h1f};
			6'd39: bits = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04};
			6'd40: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h1f};
			6'd41: bits = {5'h11, 5'h11, 5'h0a, 5'h0a, 5'h04};
			6'd42: bits = {5'h11, 5'h11, 5'h15, 5'h15, 5'h0a};
			6'd43: bits = {5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11};
			6'd44: bits = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04};
			6'd45: bits = {5'h1f, 5'h02, 5'h04, 5'h08, 5'h1f};
			// blank glyphs and codes past the font
			default: bits = '0;
		endcase
		case (r)
			3'd0: font_row = bits[5*FONT_W-1 -: FONT_W];
			3'd1: font_row = bits[4*FONT_W-1 -: FONT_W];
			3'd2: font_row = bits[3*FONT_W-1 -: FONT_W];
			3'd3: font_row = bits[2*FONT_W-1 -: FONT_W];
			3'd4: font_row = bits[FONT_W-1 -: FONT_W];
			default: font_row = '0;
		endcase
	endfunction

endpackage

@@ src/stm_glyph_ram.sv @@
module stm_glyph_ram import stm_pkg::*; (
	input  logic               clk,
	input  ram_req_t           req,
	output logic [GLYPH_W-1:0] rdata
);

	logic [GLYPH_W-1:0] mem [STORE_DEPTH];
	logic [GLYPH_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/stm_engine.sv @@
module stm_engine import stm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [2:0]                 operation,
	input  logic                       line_select,
	input  logic [IDX_W-1:0]           char_index,
	input  logic [CODE_W-1:0]          char_code,
	input  logic [ROW_W-1:0]           row_select,
	input  logic [1:0][LEN_W-1:0]      line_len,
	input  logic                       res_ready,
	output logic                       res_valid,
	output result_t                    res,
	output ram_req_t                   ram_req,
	input  logic [GLYPH_W-1:0]         ram_rdata
);

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_FETCH   = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_MID     = STEP_W'(5);
	localparam logic [STEP_W-1:0] STEP_LAST    = STEP_W'(10);
	localparam logic [STEP_W-1:0] SAY_FETCHES  = STEP_W'(SAY_GLYPHS);
	localparam logic [STEP_W-1:0] SAY_ROW_OFS  = STEP_W'(9);
	localparam logic [2:0]        LAST_COL     = 3'(CELL_W - 1);

	// Item register
	logic               valid_s1;
	logic [2:0]         op_s1;
	logic               line_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [CODE_W-1:0]  code_s1;
	logic [ROW_W-1:0]   rsel_s1;

	// Block state
	logic [STEP_W-1:0]  step_q;
	logic [1:0]         flags_q;
	logic [IDX_W-1:0]   pos_idx_q [2];
	logic [2:0]         pos_col_q [2];
	logic [GLYPH_W-1:0] say_g_q [SAY_GLYPHS];
	logic [PIX_W-1:0]   screen_q [SCREEN_ROWS];

	// Step decode
	logic               emit, done, adv, take;
	logic               row_wr, restart, say_save;
	logic [1:0]         pos_upd;
	logic [1:0]         flags_nxt;
	logic [ROW_W-1:0]   row_addr;
	logic [PIX_W-1:0]   pix_new, scr_old;
	status_t            status;
	logic               has_row;
	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_raddr;

	// Scroll positions after wrap, and the next ones
	logic [IDX_W-1:0]   idx_eff [2];
	logic [2:0]         col_eff [2];
	logic [IDX_W-1:0]   idx_nxt [2];
	logic [2:0]         col_nxt [2];
	logic [LEN_W-1:0]   idx_inc [2];

	logic               empty0, empty1, both, first_ln, tick_ln, tick_bit;
	logic [2:0]         tick_r, say_r;
	logic [ROW_W-1:0]   base [2];
	logic [FONT_W-1:0]  tick_font;
	logic [PIX_W-1:0]   say_v;
	logic [1:0]         save_idx;

	// Character mapping
	logic [CODE_W-1:0]  up_code, g8;
	logic               map_ok;
	logic [GLYPH_W-1:0] map_glyph;

	function automatic logic char_code_in_lower(input logic [CODE_W-1:0] c);
		char_code_in_lower = (c >= CODE_LOWER_A) && (c <= CODE_LOWER_Z);
	endfunction

	always_comb begin
		up_code = (char_code_in_lower(code_s1)) ? code_s1 - CASE_OFFSET : code_s1;
		g8 = up_code - GLYPH_OFFSET;
		if (code_s1 == CODE_SPACE) begin
			map_ok    = 1'b1;
			map_glyph = GLYPH_SPACE;
		end else begin
			map_ok    = g8 < CODE_W'(GLYPH_COUNT);
			map_glyph = g8[GLYPH_W-1:0];
		end
	end

	// Position wrap: a position past the line restarts at column zero
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (LEN_W'(pos_idx_q[l]) >= line_len[l]) begin
				idx_eff[l] = '0;
				col_eff[l] = '0;
			end else begin
				idx_eff[l] = pos_idx_q[l];
				col_eff[l] = pos_col_q[l];
			end
			idx_inc[l] = LEN_W'(idx_eff[l]) + LEN_W'(1);
			if (col_eff[l] == LAST_COL) begin
				col_nxt[l] = '0;
				idx_nxt[l] = (idx_inc[l] == line_len[l]) ? '0 : idx_inc[l][IDX_W-1:0];
			end else begin
				col_nxt[l] = col_eff[l] + 3'd1;
				idx_nxt[l] = idx_eff[l];
			end
		end
	end

	// Tick geometry
	always_comb begin
		empty0   = line_len[0] == '0;
		empty1   = line_len[1] == '0;
		both     = !empty0 && !empty1;
		first_ln = empty0;
		base[0]  = empty1 ? ROW_SOLO : ROW_FIRST_PAIR;
		base[1]  = empty0 ? ROW_SOLO : ROW_SECOND_PAIR;
		tick_ln  = (step_q <= STEP_MID) ? first_ln : 1'b1;
		tick_r   = (step_q <= STEP_MID) ? 3'(STEP_MID - step_q) : 3'(STEP_LAST - step_q);
		tick_font = font_row(ram_rdata, tick_r);
		// column zero of each cell is the blank gap
		if (col_eff[tick_ln] == 3'd0) begin
			tick_bit = 1'b0;
		end else begin
			tick_bit = tick_font[3'(LAST_COL - col_eff[tick_ln])];
		end
	end

	// Static text row: up to four glyphs of line one side by side
	always_comb begin
		say_r    = 3'(SAY_ROW_OFS - step_q);
		save_idx = 2'(step_q - STEP_W'(1));
		say_v    = '0;
		for (int i = 0; i < SAY_GLYPHS; i++) begin
			if (LEN_W'(i) < line_len[0]) begin
				say_v = say_v | (PIX_W'(font_row(say_g_q[i], say_r))
					<< (CELL_W * (SAY_GLYPHS - 1 - i)));
			end
		end
	end

	assign scr_old = screen_q[row_addr];

	// Step control
	always_comb begin
		emit      = 1'b0;
		done      = 1'b0;
		status    = ST_OK;
		has_row   = 1'b0;
		row_addr  = '0;
		pix_new   = '0;
		row_wr    = 1'b0;
		restart   = 1'b0;
		say_save  = 1'b0;
		pos_upd   = '0;
		flags_nxt = flags_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (valid_s1) begin
			case (op_s1)
				OP_LOAD: begin
					emit = 1'b1;
					done = 1'b1;
					if ((IDX_W+1)'(idx_s1) < (IDX_W+1)'(MAX_CHARS)) begin
						if (idx_s1 == '0) begin
							flags_nxt[line_s1] = 1'b0;
						end
						if (map_ok) begin
							ram_we = 1'b1;
						end else begin
							flags_nxt[line_s1] = 1'b1;
							status = ST_BAD_CHAR;
						end
					end
				end
				OP_RESTART: begin
					emit    = 1'b1;
					done    = 1'b1;
					restart = 1'b1;
				end
				OP_TICK: begin
					if (flags_q != '0) begin
						emit   = 1'b1;
						done   = 1'b1;
						status = ST_REFUSED;
					end else if (empty0 && empty1) begin
						emit = 1'b1;
						done = 1'b1;
					end else if (step_q == STEP_FETCH) begin
						ram_re    = 1'b1;
						ram_raddr = {first_ln, idx_eff[first_ln]};
					end else begin
						emit     = 1'b1;
						has_row  = 1'b1;
						row_addr = base[tick_ln] + ROW_W'(tick_r);
						row_wr   = 1'b1;
						pix_new  = {scr_old[PIX_W-2:0], tick_bit};
						if (step_q == STEP_MID) begin
							pos_upd[first_ln] = 1'b1;
							if (both) begin
								ram_re    = 1'b1;
								ram_raddr = {1'b1, idx_eff[1]};
							end else begin
								done = 1'b1;
							end
						end
						if (step_q == STEP_LAST) begin
							pos_upd[1] = 1'b1;
							done       = 1'b1;
						end
					end
				end
				OP_SAY: begin
					if (flags_q[0]) begin
						emit   = 1'b1;
						done   = 1'b1;
						status = ST_REFUSED;
					end else begin
						// glyph fetches overlap the saves one step behind
						if (step_q < SAY_FETCHES) begin
							ram_re    = 1'b1;
							ram_raddr = {1'b0, IDX_W'(step_q)};
						end
						if ((step_q != STEP_FETCH) && (step_q <= SAY_FETCHES)) begin
							say_save = 1'b1;
						end
						if (step_q == SAY_FETCHES) begin
							emit     = 1'b1;
							has_row  = 1'b1;
							row_addr = SAY_TOP;
							row_wr   = 1'b1;
						end else if (step_q == STEP_LAST) begin
							emit     = 1'b1;
							has_row  = 1'b1;
							row_addr = SAY_BOTTOM;
							row_wr   = 1'b1;
							done     = 1'b1;
						end else if (step_q > SAY_FETCHES) begin
							emit     = 1'b1;
							has_row  = 1'b1;
							row_addr = SAY_BASE + ROW_W'(say_r);
							row_wr   = 1'b1;
							pix_new  = say_v;
						end
					end
				end
				OP_READ: begin
					emit     = 1'b1;
					done     = 1'b1;
					has_row  = 1'b1;
					row_addr = rsel_s1;
					pix_new  = scr_old;
				end
				default: begin
					emit = 1'b1;
					done = 1'b1;
				end
			endcase
		end
	end

	assign adv        = valid_s1 && (!emit || res_ready);
	assign take       = item_valid && !item_stall;
	assign item_stall = valid_s1 && !(adv && done);
	assign res_valid  = valid_s1 && emit;

	always_comb begin
		res.status     = status;
		res.has_row    = has_row;
		res.row_index  = has_row ? row_addr : '0;
		res.row_pixels = has_row ? pix_new : '0;
		res.last       = done;
	end

	always_comb begin
		ram_req.we    = ram_we && adv;
		ram_req.waddr = {line_s1, idx_s1};
		ram_req.wdata = map_glyph;
		ram_req.re    = ram_re && adv;
		ram_req.raddr = ram_raddr;
	end

	// Item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv && done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= operation;
			line_s1 <= line_select;
			idx_s1  <= char_index;
			code_s1 <= char_code;
			rsel_s1 <= row_select;
		end
	end

	// Step counter, flags and scroll positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			flags_q <= '0;
			for (int l = 0; l < 2; l++) begin
				pos_idx_q[l] <= '0;
				pos_col_q[l] <= '0;
			end
		end else if (adv) begin
			step_q  <= done ? '0 : step_q + STEP_W'(1);
			flags_q <= flags_nxt;
			for (int l = 0; l < 2; l++) begin
				if (restart) begin
					pos_idx_q[l] <= '0;
					pos_col_q[l] <= '0;
				end else if (pos_upd[l]) begin
					pos_idx_q[l] <= idx_nxt[l];
					pos_col_q[l] <= col_nxt[l];
				end
			end
		end
	end

	// Screen store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < SCREEN_ROWS; r++) begin
				screen_q[r] <= '0;
			end
		end else if (adv && row_wr) begin
			screen_q[row_addr] <= pix_new;
		end
	end

	// Glyphs captured for static text
	always_ff @(posedge clk) begin
		if (adv && say_save) begin
			say_g_q[save_idx] <= ram_rdata;
		end
	end

endmodule

@@ src/scrolling_text_marquee.sv @@
// Channel   Handshake                  Payload
// item      item_valid / item_stall    operation, line_select, char_index, char_code, row_select
// result    result_valid / result_stall status, has_row, row_index, row_pixels, last
// config    cfg_write_en               cfg_index, cfg_data
//
// Load, restart, read_row, refused items and unused codes each give a single result.
// A tick reads one glyph from the glyph store per non-empty line, then writes that
// line's five screen rows, one per cycle unless results stall.
// say makes four glyph reads, then writes seven rows, one per cycle unless results stall.
// Reset clears screen rows, positions, flags and lengths; the glyph store is not cleared.
// A result waits in the output register under result_stall while the next item is taken.
module scrolling_text_marquee import stm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [2:0]         operation,
	input  logic               line_select,
	input  logic [IDX_W-1:0]   char_index,
	input  logic [CODE_W-1:0]  char_code,
	input  logic [ROW_W-1:0]   row_select,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         status,
	output logic               has_row,
	output logic [ROW_W-1:0]   row_index,
	output logic [PIX_W-1:0]   row_pixels,
	output logic               last,
	input  logic               cfg_write_en,
	input  logic               cfg_index,
	input  logic [LEN_W-1:0]   cfg_data
);

	logic [LEN_W-1:0]      len_q [2];
	logic [1:0][LEN_W-1:0] line_len;
	logic                  res_ready, res_valid;
	result_t               res, res_q;
	logic                  out_valid_q;
	ram_req_t              ram_req;
	logic [GLYPH_W-1:0]    ram_rdata;

	// Line length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0] <= '0;
			len_q[1] <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_FIRST_LEN:  len_q[0] <= cfg_data;
				CFG_SECOND_LEN: len_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Lengths beyond the store are clamped
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			line_len[l] = (len_q[l] > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : len_q[l];
		end
	end

	stm_glyph_ram u_glyph_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	stm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (operation),
		.line_select (line_select),
		.char_index  (char_index),
		.char_code   (char_code),
		.row_select  (row_select),
		.line_len    (line_len),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata)
	);

	// Output register
	assign res_ready = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = res_q.status;
	assign has_row      = res_q.has_row;
	assign row_index    = res_q.row_index;
	assign row_pixels   = res_q.row_pixels;
	assign last         = res_q.last;

endmodule

@@ src/stm_checker.sv @@
module stm_checker import stm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input logic [1:0]       status,
	input logic             has_row,
	input logic [ROW_W-1:0] row_index,
	input logic [PIX_W-1:0] row_pixels,
	input logic             last
);

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			$stable(row_pixels) && $stable(row_index) && $stable(last) && $stable(status))
		else $error("result payload changed while stalled");

	// Results without a row carry zero row fields
	a_no_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_row |-> (row_index == '0) && (row_pixels == '0))
		else $error("row fields set on a result without a row");

	// An error or refusal is the only result of its item
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != 2'(ST_OK)) |-> !has_row && last)
		else $error("error status on a row result or a result that is not last");

endmodule

bind scrolling_text_marquee stm_checker u_stm_checker (.*);

@@ tb/scrolling_text_marquee_tb.sv @@
`timescale 1ns / 100ps

module scrolling_text_marquee_tb;
	import stm_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 23;

	// one command for the marquee
	typedef struct {
		logic [2:0]        op;
		logic              ln;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] code;
		logic [ROW_W-1:0]  rsel;
	} marquee_cmd_t;

	// 5x5 font, leftmost pixel in bit 4
	localparam logic [FONT_W-1:0] GLYPH_ART [GLYPH_COUNT][5] = '{
		'{5'h00, 5'h00, 5'h1f, 5'h00, 5'h00}, '{5'h00, 5'h00, 5'h00, 5'h00, 5'h04},
		'{5'h02, 5'h02, 5'h04, 5'h08, 5'h08}, '{5'h1f, 5'h13, 5'h15, 5'h19, 5'h1f},
		'{5'h04, 5'h0c, 5'h04, 5'h04, 5'h0e}, '{5'h1e, 5'h01, 5'h0e, 5'h10, 5'h1f},
		'{5'h1f, 5'h01, 5'h0e, 5'h01, 5'h1f}, '{5'h10, 5'h10, 5'h14, 5'h1f, 5'h04},
		'{5'h1f, 5'h10, 5'h1e, 5'h01, 5'h1e}, '{5'h1f, 5'h10, 5'h1f, 5'h11, 5'h1f},
		'{5'h1f, 5'h01, 5'h02, 5'h04, 5'h04}, '{5'h1f, 5'h11, 5'h1f, 5'h11, 5'h1f},
		'{5'h1f, 5'h11, 5'h1f, 5'h01, 5'h1f}, '{5'h00, 5'h04, 5'h00, 5'h04, 5'h00},
		'{5'h00, 5'h04, 5'h00, 5'h04, 5'h04}, '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h00, 5'h1f, 5'h00, 5'h1f, 5'h00}, '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h1f, 5'h11, 5'h11, 5'h1f, 5'h11}, '{5'h1f, 5'h11, 5'h1e, 5'h11, 5'h1f},
		'{5'h1f, 5'h10, 5'h10, 5'h10, 5'h1f}, '{5'h1e, 5'h11, 5'h11, 5'h11, 5'h1e},
		'{5'h1f, 5'h10, 5'h1e, 5'h10, 5'h1f}, '{5'h1f, 5'h10, 5'h1e, 5'h10, 5'h10},
		'{5'h1f, 5'h10, 5'h13, 5'h11, 5'h1f}, '{5'h11, 5'h11, 5'h1f, 5'h11, 5'h11},
		'{5'h1f, 5'h04, 5'h04, 5'h04, 5'h1f}, '{5'h03, 5'h01, 5'h01, 5'h11, 5'h1f},
		'{5'h11, 5'h12, 5'h1c, 5'h12, 5'h11}, '{5'h10, 5'h10, 5'h10, 5'h10, 5'h1f},
		'{5'h11, 5'h1b, 5'h15, 5'h11, 5'h11}, '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
		'{5'h0e, 5'h11, 5'h11, 5'h11, 5'h0e}, '{5'h1e, 5'h11, 5'h1e, 5'h10, 5'h10},
		'{5'h1f, 5'h11, 5'h11, 5'h1f, 5'h04}, '{5'h1e, 5'h11, 5'h1e, 5'h11, 5'h11},
		'{5'h1f, 5'h10, 5'h1f, 5'h01, 5'h1f}, '{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h1f}, '{5'h11, 5'h11, 5'h0a, 5'h0a, 5'h04},
		'{5'h11, 5'h11, 5'h15, 5'h15, 5'h0a}, '{5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11},
		'{5'h11, 5'h11, 5'h0a, 5'h04, 5'h04}, '{5'h1f, 5'h02, 5'h04, 5'h08, 5'h1f}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [2:0]         operation = '0;
	logic               line_select = 1'b0;
	logic [IDX_W-1:0]   char_index = '0;
	logic [CODE_W-1:0]  char_code = '0;
	logic [ROW_W-1:0]   row_select = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         status;
	logic               has_row;
	logic [ROW_W-1:0]   row_index;
	logic [PIX_W-1:0]   row_pixels;
	logic               last;
	logic               cfg_write_en = 1'b0;
	logic               cfg_index = 1'b0;
	logic [LEN_W-1:0]   cfg_data = '0;

	// marquee state as the testbench sees it
	logic [GLYPH_W-1:0] glyph_store [STORE_DEPTH];
	logic [PIX_W-1:0]   screen_image [SCREEN_ROWS];
	logic [7:0]         scroll_col [2];
	logic [1:0]         bad_lines;
	logic [LEN_W-1:0]   line_len [2];

	marquee_cmd_t pending_cmds [$];
	result_t      expected_rows [$];
	marquee_cmd_t next_cmd;
	result_t      want;

	logic calm = 1'b0;
	int   send_wait;
	int   hold_left;
	int   idle_cycles = 0;
	int   fails = 0;
	int   items_taken = 0;
	int   results_checked = 0;
	int   rows_checked = 0;
	int   settings_used = 0;

	scrolling_text_marquee dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.line_select  (line_select),
		.char_index   (char_index),
		.char_code    (char_code),
		.row_select   (row_select),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.has_row      (has_row),
		.row_index    (row_index),
		.row_pixels   (row_pixels),
		.last         (last),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// character byte to glyph number; returns whether the glyph exists
	function automatic logic glyph_for_code(input logic [CODE_W-1:0] c,
			output logic [GLYPH_W-1:0] g);
		logic [CODE_W-1:0] up;
		if (c == CODE_SPACE) begin
			g = GLYPH_SPACE;
			return 1'b1;
		end
		up = (c >= CODE_LOWER_A && c <= CODE_LOWER_Z) ? c - CASE_OFFSET : c;
		up = up - GLYPH_OFFSET;
		g = up[GLYPH_W-1:0];
		return up < GLYPH_COUNT;
	endfunction

	function automatic logic [CODE_W-1:0] valid_code();
		logic [CODE_W-1:0] c;
		int unsigned g;
		g = $urandom_range(0, GLYPH_COUNT - 1);
		if (g == GLYPH_SPACE && $urandom_range(0, 1))
			return CODE_SPACE;
		c = CODE_W'(g) + GLYPH_OFFSET;
		// letters arrive in either case
		if (c >= CODE_LOWER_A - CASE_OFFSET && c <= CODE_LOWER_Z - CASE_OFFSET
				&& $urandom_range(0, 1))
			c = c + CASE_OFFSET;
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] invalid_code();
		logic [CODE_W-1:0] c;
		logic [GLYPH_W-1:0] g;
		do
			c = CODE_W'($urandom_range(0, 255));
		while (glyph_for_code(c, g));
		return c;
	endfunction

	function automatic result_t row_report(input status_t st, input logic has,
			input logic [ROW_W-1:0] row);
		result_t rep;
		rep.status = st;
		rep.has_row = has;
		rep.row_index = has ? row : '0;
		rep.row_pixels = has ? screen_image[row] : '0;
		rep.last = 1'b0;
		return rep;
	endfunction

	// marquee behavior for one transfer; queues the rows it reports
	task automatic predict_item(input logic [2:0] op, input logic ln,
			input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code,
			input logic [ROW_W-1:0] rsel);
		result_t batch [$];
		int unsigned len [2];
		int unsigned base [2];
		int unsigned span, col, cnt;
		int i, r, ci;
		logic [GLYPH_W-1:0] g;
		logic [CELL_W-1:0] glyph_bits;
		logic [ROW_W-1:0] row_now;
		logic [PIX_W-1:0] v;
		for (i = 0; i < 2; i++)
			len[i] = line_len[i] > MAX_CHARS ? MAX_CHARS : line_len[i];
		case (op)
			OP_LOAD: begin
				if (idx == 0)
					bad_lines[ln] = 1'b0;
				if (glyph_for_code(code, g)) begin
					glyph_store[{ln, idx}] = g;
					batch.push_back(row_report(ST_OK, 1'b0, '0));
				end else begin
					bad_lines[ln] = 1'b1;
					batch.push_back(row_report(ST_BAD_CHAR, 1'b0, '0));
				end
			end
			OP_RESTART: begin
				scroll_col[0] = '0;
				scroll_col[1] = '0;
				batch.push_back(row_report(ST_OK, 1'b0, '0));
			end
			OP_TICK: begin
				if (bad_lines != 0) begin
					batch.push_back(row_report(ST_REFUSED, 1'b0, '0));
				end else begin
					base[0] = len[1] == 0 ? ROW_SOLO : ROW_FIRST_PAIR;
					base[1] = len[0] == 0 ? ROW_SOLO : ROW_SECOND_PAIR;
					for (i = 0; i < 2; i++) begin
						if (len[i] != 0) begin
							span = len[i] * CELL_W;
							col = scroll_col[i];
							// a shortened line restarts from its first column
							if (col >= span)
								col = 0;
							for (r = 4; r >= 0; r--) begin
								row_now = ROW_W'(base[i] + r);
								glyph_bits = {1'b0,
									GLYPH_ART[glyph_store[ADDR_W'(i * MAX_CHARS + col / CELL_W)]][r]};
								screen_image[row_now] = {screen_image[row_now][PIX_W-2:0],
									glyph_bits[CELL_W - 1 - col % CELL_W]};
								batch.push_back(row_report(ST_OK, 1'b1, row_now));
							end
							scroll_col[i] = 8'((col + 1) % span);
						end
					end
					if (batch.size() == 0)
						batch.push_back(row_report(ST_OK, 1'b0, '0));
				end
			end
			OP_SAY: begin
				if (bad_lines[0]) begin
					batch.push_back(row_report(ST_REFUSED, 1'b0, '0));
				end else begin
					cnt = len[0] < SAY_GLYPHS ? len[0] : SAY_GLYPHS;
					screen_image[SAY_TOP] = '0;
					batch.push_back(row_report(ST_OK, 1'b1, SAY_TOP));
					for (r = 4; r >= 0; r--) begin
						v = '0;
						for (ci = 0; ci < cnt; ci++)
							v |= PIX_W'(GLYPH_ART[glyph_store[ci]][r])
								<< (PIX_W - CELL_W - CELL_W * ci);
						row_now = ROW_W'(SAY_BASE + r);
						screen_image[row_now] = v;
						batch.push_back(row_report(ST_OK, 1'b1, row_now));
					end
					screen_image[SAY_BOTTOM] = '0;
					batch.push_back(row_report(ST_OK, 1'b1, SAY_BOTTOM));
				end
			end
			OP_READ: batch.push_back(row_report(ST_OK, 1'b1, rsel));
			default: batch.push_back(row_report(ST_OK, 1'b0, '0));
		endcase
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			expected_rows.push_back(batch[k]);
	endtask

	task automatic push_cmd(input logic [2:0] op, input logic ln, input logic [IDX_W-1:0] idx,
			input logic [CODE_W-1:0] code, input logic [ROW_W-1:0] rsel);
		marquee_cmd_t c;
		c.op = op;
		c.ln = ln;
		c.idx = idx;
		c.code = code;
		c.rsel = rsel;
		pending_cmds.push_back(c);
	endtask

	// scrolling traffic over loaded text, ticks most often, with some bad characters and noise
	task automatic queue_random_item();
		marquee_cmd_t c;
		int unsigned pick, extra;
		c.op = OP_READ;
		c.ln = 1'($urandom_range(0, 1));
		c.idx = IDX_W'($urandom_range(0, MAX_CHARS - 1));
		c.code = CODE_W'($urandom_range(0, 255));
		c.rsel = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			c.op = OP_TICK;
		end else if (pick < 48) begin
			c.op = OP_SAY;
		end else if (pick < 58) begin
			c.op = OP_READ;
		end else if (pick < 80) begin
			c.op = OP_LOAD;
			c.code = valid_code();
		end else if (pick < 86) begin
			c.op = OP_RESTART;
		end else if (pick < 93) begin
			// bad character, up to two ticks or says, then recovery through index 0
			c.op = OP_LOAD;
			c.code = invalid_code();
			pending_cmds.push_back(c);
			extra = $urandom_range(0, 2);
			repeat (extra) begin
				c.op = $urandom_range(0, 1) ? OP_TICK : OP_SAY;
				pending_cmds.push_back(c);
			end
			c.op = OP_LOAD;
			c.idx = '0;
			c.code = valid_code();
		end else begin
			c.op = 3'($urandom_range(5, 7));
		end
		pending_cmds.push_back(c);
	endtask

	// block drained: nothing queued, nothing in flight, nothing owed
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || item_valid || expected_rows.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_lengths(input logic [LEN_W-1:0] first_len,
			input logic [LEN_W-1:0] second_len);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_FIRST_LEN;
		cfg_data <= first_len;
		@(posedge clk);
		cfg_index <= CFG_SECOND_LEN;
		cfg_data <= second_len;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		line_len[0] = first_len;
		line_len[1] = second_len;
		settings_used++;
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_wait = 0;
		end else if (!(item_valid && item_stall)) begin
			if (item_valid) begin
				predict_item(operation, line_select, char_index, char_code, row_select);
				items_taken++;
			end
			if (send_wait != 0) begin
				send_wait--;
				item_valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				operation <= next_cmd.op;
				line_select <= next_cmd.ln;
				char_index <= next_cmd.idx;
				char_code <= next_cmd.code;
				row_select <= next_cmd.rsel;
				item_valid <= 1'b1;
				send_wait = calm ? 0 : $urandom_range(0, 10);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_checked++;
				if (expected_rows.size() == 0) begin
					$error("result transfer with nothing expected (row %0d, pixels %h)",
						row_index, row_pixels);
					fails++;
				end else begin
					want = expected_rows.pop_front();
					if (want.has_row)
						rows_checked++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (has_row !== want.has_row) begin
						$error("has_row: expected %0d, got %0d", want.has_row, has_row);
						fails++;
					end
					if (row_index !== want.row_index) begin
						$error("row_index: expected %0d, got %0d", want.row_index, row_index);
						fails++;
					end
					if (row_pixels !== want.row_pixels) begin
						$error("row_pixels: expected %h, got %h", want.row_pixels, row_pixels);
						fails++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fails++;
					end
				end
				hold_left = calm ? 0 : $urandom_range(0, 10);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			result_stall <= (hold_left != 0);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [LEN_W-1:0] first_set [9];
		logic [LEN_W-1:0] second_set [9];
		int p, ln, ix;

		// reset picture of the marquee
		foreach (screen_image[k])
			screen_image[k] = '0;
		scroll_col[0] = '0;
		scroll_col[1] = '0;
		bad_lines = '0;
		line_len[0] = '0;
		line_len[1] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty lines, every operation, mapping corners, flag handling
		push_cmd(OP_TICK, 1'b0, 5'd0, 8'h00, 4'd0);
		push_cmd(OP_SAY, 1'b1, 5'd31, 8'hff, 4'd15);
		push_cmd(OP_READ, 1'b0, 5'd0, 8'h00, 4'd0);
		push_cmd(OP_READ, 1'b1, 5'd31, 8'hff, 4'd15);
		push_cmd(OP_RESTART, 1'b0, 5'd3, 8'h41, 4'd7);
		push_cmd(3'd5, 1'b1, 5'd10, 8'h55, 4'd5);
		push_cmd(3'd6, 1'b0, 5'd21, 8'haa, 4'd10);
		push_cmd(3'd7, 1'b1, 5'd31, 8'hff, 4'd15);
		push_cmd(OP_LOAD, 1'b0, 5'd0, CODE_SPACE, 4'd0);
		push_cmd(OP_LOAD, 1'b0, 5'd1, 8'h61, 4'd0);
		push_cmd(OP_LOAD, 1'b0, 5'd2, 8'h7a, 4'd0);
		push_cmd(OP_LOAD, 1'b0, 5'd3, 8'h2d, 4'd0);
		push_cmd(OP_LOAD, 1'b1, 5'd31, 8'h5a, 4'd0);
		push_cmd(OP_LOAD, 1'b1, 5'd5, 8'h5b, 4'd0);
		push_cmd(OP_TICK, 1'b0, 5'd0, 8'h00, 4'd0);
		push_cmd(OP_SAY, 1'b0, 5'd0, 8'h00, 4'd0);
		push_cmd(OP_LOAD, 1'b0, 5'd7, 8'hff, 4'd0);
		push_cmd(OP_SAY, 1'b0, 5'd0, 8'h00, 4'd0);
		push_cmd(OP_LOAD, 1'b0, 5'd0, 8'h2c, 4'd0);
		push_cmd(OP_LOAD, 1'b0, 5'd0, 8'h40, 4'd0);
		push_cmd(OP_LOAD, 1'b1, 5'd0, 8'h7b, 4'd0);
		push_cmd(OP_LOAD, 1'b1, 5'd0, 8'h2e, 4'd0);
		push_cmd(OP_TICK, 1'b0, 5'd0, 8'h00, 4'd0);
		wait_drained();

		// fill both text lines so any length reads written glyphs
		for (ln = 0; ln < 2; ln++)
			for (ix = 0; ix < MAX_CHARS; ix++)
				push_cmd(OP_LOAD, 1'(ln), IDX_W'(ix), valid_code(),
					ROW_W'($urandom_range(0, SCREEN_ROWS - 1)));

		// length settings: single lines, both full, clamped, shrinking, random
		first_set  = '{6'd1, 6'd32, 6'd0, 6'd7, 6'd63, 6'd3, 6'd0, 6'd0, 6'd32};
		second_set = '{6'd1, 6'd32, 6'd5, 6'd0, 6'd2, 6'd40, 6'd0, 6'd0, 6'd1};
		first_set[7] = LEN_W'($urandom_range(0, 63));
		second_set[7] = LEN_W'($urandom_range(0, 63));
		for (p = 0; p < 9; p++) begin
			wait_drained();
			set_lengths(first_set[p], second_set[p]);
			calm = (p % 3 == 2);
			repeat (PHASE_ITEMS) queue_random_item();
		end
		wait_drained();

		$display("Ran %0d transfers in over %0d length settings.", items_taken, settings_used);
		$display("Checked %0d results, %0d of them screen rows.", results_checked, rows_checked);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/stm_pkg.sv
src/stm_glyph_ram.sv
src/stm_engine.sv
src/scrolling_text_marquee.sv
src/stm_checker.sv
tb/scrolling_text_marquee_tb.sv
